// ===== sv/assert_macros.svh =====
// Assertion macros shared by the date, time and alarm setter RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/dtas_pkg.sv =====
// Types, codes and calendar helpers for the date, time and alarm setter.
// No dependencies; used by date_time_alarm_setter_core.
package dtas_pkg;

  localparam int NUM_FIELDS  = 6;
  localparam int LEAP_PERIOD = 4;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_MODE  = 3'd1;
  localparam logic [2:0] OP_FIELD = 3'd2;
  localparam logic [2:0] OP_UP    = 3'd3;
  localparam logic [2:0] OP_DOWN  = 3'd4;

  localparam logic [1:0] MODE_CODE_SHOW  = 2'd0;
  localparam logic [1:0] MODE_CODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_CODE_ALARM = 2'd2;
  localparam logic [1:0] MODE_CODE_WATCH = 2'd3;

  localparam logic [4:0] DAYS_LONG     = 5'd31;
  localparam logic [4:0] DAYS_SHORT    = 5'd30;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB      = 5'd28;

  typedef enum logic [3:0] {
    MODE_SHOW  = 4'b0001,
    MODE_TIME  = 4'b0010,
    MODE_ALARM = 4'b0100,
    MODE_WATCH = 4'b1000
  } mode_t;

  typedef logic [6:0] fld_t;
  typedef fld_t [NUM_FIELDS-1:0] fields_t;
  typedef logic signed [8:0] work_t;

  localparam fields_t FIELD_MAX = {7'd59, 7'd59, 7'd23, 7'd31, 7'd12, 7'd99};
  localparam fields_t FIELD_MIN = {7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd0};

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] field_select;
    logic [6:0] show_year;
    logic [3:0] show_month;
    logic [4:0] show_day;
    logic [4:0] show_hour;
    logic [5:0] show_minute;
    logic [5:0] show_second;
    logic       rtc_write;
  } out_item_t;

  // Days in month m of year y; zero when m is not a valid month.
  function automatic logic [4:0] month_len(input fld_t y, input work_t m);
    logic [4:0] len;
    if (m == 9'sd2) begin
      len = ((y % 7'(LEAP_PERIOD)) == 7'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (m == 9'sd4 || m == 9'sd6 || m == 9'sd9 || m == 9'sd11) begin
      len = DAYS_SHORT;
    end else if (m >= 9'sd1 && m <= 9'sd12) begin
      len = DAYS_LONG;
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

endpackage

// ===== sv/date_time_alarm_setter_core.sv =====
// Date, time and alarm setter: key-driven editing of time and alarm fields.
// Depends on dtas_pkg and assert_macros.svh.
//
// One key event with a clock reading is taken per cycle while the output is not
// held by out_ready, and one result comes out per event, through the input
// register and then the result register. The rate is set by the update of mode,
// selector and fields, including the alarm raise, that each event makes before the next.
module date_time_alarm_setter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtas_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtas_pkg::out_item_t  out_data
);
  import dtas_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  mode_t     mode_r, mode_nxt;
  logic [2:0] fi_r, fi_nxt;
  fields_t   time_r, time_nxt;
  fields_t   alarm_r, alarm_nxt;
  fields_t   edited;
  fields_t   src;
  logic      wr;
  logic      adv;
  out_item_t res;

  function automatic logic [2:0] next_field(input logic [2:0] fi);
    return (fi >= FLD_SECOND) ? fi - FLD_SECOND : fi + 3'd1;
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_SHOW:  c = MODE_CODE_SHOW;
      MODE_TIME:  c = MODE_CODE_TIME;
      MODE_ALARM: c = MODE_CODE_ALARM;
      default:    c = MODE_CODE_WATCH;
    endcase
    return c;
  endfunction

  function automatic fields_t step_up(input fields_t f, input logic [2:0] sel);
    work_t      v [NUM_FIELDS];
    logic [4:0] len;
    fields_t    r;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      v[i] = signed'({2'b00, f[i]});
      if (3'(i) == sel) begin
        v[i] = v[i] + 9'sd1;
      end
    end
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (i != int'(FLD_DAY) && v[i] > signed'({2'b00, FIELD_MAX[i]})) begin
        v[i] = signed'({2'b00, FIELD_MIN[i]});
      end
    end
    len = month_len(v[FLD_YEAR][6:0], v[FLD_MONTH]);
    if (len != 5'd0 && v[FLD_DAY] > signed'({4'b0000, len})) begin
      v[FLD_DAY] = 9'sd1;
    end
    for (int i = 0; i < NUM_FIELDS; i++) begin
      r[i] = v[i][6:0];
    end
    return r;
  endfunction

  function automatic fields_t step_down(input fields_t f, input logic [2:0] sel);
    work_t      v [NUM_FIELDS];
    logic [4:0] len;
    fields_t    r;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      v[i] = signed'({2'b00, f[i]});
      if (3'(i) == sel) begin
        v[i] = v[i] - 9'sd1;
      end
    end
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (i != int'(FLD_DAY) && v[i] < signed'({2'b00, FIELD_MIN[i]})) begin
        v[i] = signed'({2'b00, FIELD_MAX[i]});
      end
    end
    len = month_len(v[FLD_YEAR][6:0], v[FLD_MONTH]);
    if (len != 5'd0) begin
      if (v[FLD_DAY] < 9'sd1) begin
        v[FLD_DAY] = signed'({4'b0000, len});
      end
      if (v[FLD_DAY] > signed'({4'b0000, len})) begin
        v[FLD_DAY] = 9'sd1;
      end
    end
    for (int i = 0; i < NUM_FIELDS; i++) begin
      r[i] = v[i][6:0];
    end
    return r;
  endfunction

  // The alarm is raised field by field while it still matches the time so far.
  function automatic fields_t raise_alarm(input fields_t a, input fields_t t);
    logic    same;
    fields_t r;
    r    = a;
    same = 1'b1;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (same && r[i] < t[i]) begin
        r[i] = t[i];
      end
      same = same && (r[i] == t[i]);
    end
    return r;
  endfunction

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_comb begin
    mode_nxt  = mode_r;
    fi_nxt    = fi_r;
    time_nxt  = time_r;
    alarm_nxt = alarm_r;
    wr        = 1'b0;
    edited    = time_r;
    if (in_data_r.op == OP_MODE) begin
      case (mode_r)
        MODE_SHOW: begin
          mode_nxt = MODE_TIME;
          fi_nxt   = FLD_YEAR;
        end
        MODE_TIME: begin
          mode_nxt  = MODE_ALARM;
          fi_nxt    = FLD_YEAR;
          wr        = 1'b1;
          alarm_nxt = time_r;
        end
        MODE_ALARM: mode_nxt = MODE_WATCH;
        default:    mode_nxt = MODE_SHOW;
      endcase
    end
    case (mode_nxt)
      MODE_SHOW: begin
        time_nxt[FLD_YEAR]   = in_data_r.rtc_year;
        time_nxt[FLD_MONTH]  = {3'b000, in_data_r.rtc_month};
        time_nxt[FLD_DAY]    = {2'b00, in_data_r.rtc_day};
        time_nxt[FLD_HOUR]   = {2'b00, in_data_r.rtc_hour};
        time_nxt[FLD_MINUTE] = {1'b0, in_data_r.rtc_minute};
        time_nxt[FLD_SECOND] = {1'b0, in_data_r.rtc_second};
      end
      MODE_TIME, MODE_ALARM: begin
        if (in_data_r.op == OP_FIELD) begin
          fi_nxt = next_field(fi_nxt);
        end else if ((in_data_r.op == OP_UP || in_data_r.op == OP_DOWN)
                     && fi_nxt <= FLD_SECOND) begin
          if (mode_nxt == MODE_TIME) begin
            edited = (in_data_r.op == OP_UP) ? step_up(time_nxt, fi_nxt)
                                             : step_down(time_nxt, fi_nxt);
            time_nxt = edited;
          end else begin
            edited = (in_data_r.op == OP_UP) ? step_up(alarm_nxt, fi_nxt)
                                             : step_down(alarm_nxt, fi_nxt);
            alarm_nxt = raise_alarm(edited, time_nxt);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    src = (mode_nxt == MODE_ALARM) ? alarm_nxt : time_nxt;
    res.mode         = mode_code(mode_nxt);
    res.field_select = fi_nxt;
    res.show_year    = src[FLD_YEAR];
    res.show_month   = src[FLD_MONTH][3:0];
    res.show_day     = src[FLD_DAY][4:0];
    res.show_hour    = src[FLD_HOUR][4:0];
    res.show_minute  = src[FLD_MINUTE][5:0];
    res.show_second  = src[FLD_SECOND][5:0];
    res.rtc_write    = wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_SHOW;
      fi_r        <= FLD_YEAR;
      time_r      <= '0;
      alarm_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        fi_r        <= fi_nxt;
        time_r      <= time_nxt;
        alarm_r     <= alarm_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_IMP(a_mode_onehot, 1'b1, $onehot(mode_r), "mode register lost its one-hot code")
  `ASSERT_IMP(a_write_in_alarm, out_valid_r && out_data_r.rtc_write,
              out_data_r.mode == MODE_CODE_ALARM && out_data_r.field_select == FLD_YEAR,
              "clock write strobe outside entry to alarm setting")
  `ASSERT_IMP(a_field_range, out_valid_r, out_data_r.field_select <= FLD_SECOND,
              "field selector out of range")
  `ASSERT_NXT(a_adv_result, adv, out_valid_r, "processed item produced no result")

endmodule

// ===== dv/date_time_alarm_setter_core_test.sv =====
// Self-checking testbench for date_time_alarm_setter_core: directed key table, then random keys.
// Results are checked against typed table rows or an in-bench model of mode, field and alarm.
// Depends on dtas_pkg and the core RTL only.
module date_time_alarm_setter_core_test;
  import dtas_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED = 26;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    in_item_t key;
    logic typed;
    out_item_t want;
  } key_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  logic [1:0] pm_mode;
  logic [2:0] pm_field;
  fld_t pm_time [NUM_FIELDS];
  fld_t pm_alarm [NUM_FIELDS];

  out_item_t pending_results[$];
  int mismatches = 0;
  int results_checked = 0;
  int writes_seen = 0;
  int alarm_results = 0;
  int keys_sent = 0;
  int idle_cycles = 0;
  int ready_left = 0;
  bit out_calm = 1'b0;

  key_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_NONE, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_SHOW, FLD_YEAR, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{'{OP_UP, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b1,
      '{MODE_CODE_SHOW, FLD_YEAR, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0}},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_YEAR, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0}},
    '{'{OP_FIELD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_MONTH, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0}},
    '{'{OP_FIELD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_DAY, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0}},
    '{'{OP_DOWN, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_DAY, 7'd127, 4'd15, 5'd30, 5'd31, 6'd63, 6'd63, 1'b0}},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
      '{MODE_CODE_SHOW, FLD_YEAR, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_YEAR, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_YEAR, 7'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{'{OP_DOWN, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{MODE_CODE_TIME, FLD_YEAR, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{'{OP_FIELD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_FIELD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_DOWN, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_FIELD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_UP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_SPARE_HI, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_DOWN, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{OP_MODE, 7'd24, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30}, 1'b0, '0}
  };

  date_time_alarm_setter_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int month_days(int y, int m);
    if (m == 2) begin
      return (y % LEAP_PERIOD == 0) ? int'(DAYS_FEB_LEAP) : int'(DAYS_FEB);
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return int'(DAYS_SHORT);
    end
    if (m >= 1 && m <= 12) begin
      return int'(DAYS_LONG);
    end
    return 0;
  endfunction

  // Steps the selected field, wraps every field but the day into range, then fixes the day.
  function automatic void nudge_field(bit on_alarm, bit up);
    int v [NUM_FIELDS];
    int len;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      v[i] = on_alarm ? int'(pm_alarm[i]) : int'(pm_time[i]);
    end
    v[pm_field] += up ? 1 : -1;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (i != int'(FLD_DAY)) begin
        if (up && v[i] > int'(FIELD_MAX[i])) v[i] = int'(FIELD_MIN[i]);
        if (!up && v[i] < int'(FIELD_MIN[i])) v[i] = int'(FIELD_MAX[i]);
      end
    end
    len = month_days(v[FLD_YEAR], v[FLD_MONTH]);
    if (len != 0) begin
      if (!up && v[FLD_DAY] < 1) v[FLD_DAY] = len;
      if (v[FLD_DAY] > len) v[FLD_DAY] = 1;
    end
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (on_alarm) pm_alarm[i] = v[i][6:0];
      else pm_time[i] = v[i][6:0];
    end
  endfunction

  function automatic out_item_t setter_step(in_item_t k);
    out_item_t r;
    fld_t shown [NUM_FIELDS];
    bit same;
    r = '0;
    if (k.op == OP_MODE) begin
      case (pm_mode)
        MODE_CODE_SHOW: begin
          pm_mode = MODE_CODE_TIME;
          pm_field = FLD_YEAR;
        end
        MODE_CODE_TIME: begin
          pm_mode = MODE_CODE_ALARM;
          pm_field = FLD_YEAR;
          r.rtc_write = 1'b1;
          pm_alarm = pm_time;
        end
        MODE_CODE_ALARM: pm_mode = MODE_CODE_WATCH;
        default: pm_mode = MODE_CODE_SHOW;
      endcase
    end
    if (pm_mode == MODE_CODE_SHOW) begin
      pm_time[FLD_YEAR] = k.rtc_year;
      pm_time[FLD_MONTH] = {3'b000, k.rtc_month};
      pm_time[FLD_DAY] = {2'b00, k.rtc_day};
      pm_time[FLD_HOUR] = {2'b00, k.rtc_hour};
      pm_time[FLD_MINUTE] = {1'b0, k.rtc_minute};
      pm_time[FLD_SECOND] = {1'b0, k.rtc_second};
    end else if (pm_mode == MODE_CODE_TIME || pm_mode == MODE_CODE_ALARM) begin
      if (k.op == OP_FIELD) begin
        pm_field = (pm_field == FLD_SECOND) ? FLD_YEAR : pm_field + 3'd1;
      end else if ((k.op == OP_UP || k.op == OP_DOWN) && pm_field < 3'(NUM_FIELDS)) begin
        nudge_field(pm_mode == MODE_CODE_ALARM, k.op == OP_UP);
        if (pm_mode == MODE_CODE_ALARM) begin
          same = 1'b1;
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (same && pm_alarm[i] < pm_time[i]) pm_alarm[i] = pm_time[i];
            same = same && (pm_alarm[i] == pm_time[i]);
          end
        end
      end
    end
    if (pm_mode == MODE_CODE_ALARM) begin
      shown = pm_alarm;
    end else begin
      shown = pm_time;
    end
    r.mode = pm_mode;
    r.field_select = pm_field;
    r.show_year = shown[FLD_YEAR];
    r.show_month = shown[FLD_MONTH][3:0];
    r.show_day = shown[FLD_DAY][4:0];
    r.show_hour = shown[FLD_HOUR][4:0];
    r.show_minute = shown[FLD_MINUTE][5:0];
    r.show_second = shown[FLD_SECOND][5:0];
    return r;
  endfunction

  function automatic int gap_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  // Mostly well-formed editing in the two set modes; the rest is mode hops and noise.
  function automatic in_item_t make_key();
    in_item_t k;
    int unsigned r;
    r = $urandom_range(99);
    if (pm_mode == MODE_CODE_TIME || pm_mode == MODE_CODE_ALARM) begin
      if (r < 4) k.op = OP_MODE;
      else if (r < 25) k.op = OP_FIELD;
      else if (r < 58) k.op = OP_UP;
      else if (r < 90) k.op = OP_DOWN;
      else if (r < 95) k.op = OP_NONE;
      else k.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else begin
      k.op = (r < 30) ? OP_MODE : 3'($urandom_range(7));
    end
    r = $urandom_range(99);
    if (r < 12) begin
      k.rtc_year = 7'($urandom);
      k.rtc_month = 4'($urandom);
      k.rtc_day = 5'($urandom);
      k.rtc_hour = 5'($urandom);
      k.rtc_minute = 6'($urandom);
      k.rtc_second = 6'($urandom);
    end else begin
      k.rtc_year = 7'($urandom_range(99));
      k.rtc_month = 4'($urandom_range(1, 12));
      k.rtc_day = 5'($urandom_range(1, 31));
      k.rtc_hour = 5'($urandom_range(23));
      k.rtc_minute = 6'($urandom_range(59));
      k.rtc_second = 6'($urandom_range(59));
      if (r < 27) begin
        k.rtc_month = 4'd2;
        k.rtc_day = 5'($urandom_range(28, 29));
      end
    end
    return k;
  endfunction

  task automatic send_key(in_item_t k, bit typed, out_item_t want, bit calm);
    int gap;
    out_item_t got;
    gap = gap_len(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= k;
    do @(posedge clk); while (!in_ready);
    got = setter_step(k);
    pending_results.push_back(typed ? want : got);
    keys_sent++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch in %s on result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.mode != want.mode)
          report_mismatch("mode", out_data.mode, want.mode);
        if (out_data.field_select != want.field_select)
          report_mismatch("field_select", out_data.field_select, want.field_select);
        if (out_data.show_year != want.show_year)
          report_mismatch("show_year", out_data.show_year, want.show_year);
        if (out_data.show_month != want.show_month)
          report_mismatch("show_month", out_data.show_month, want.show_month);
        if (out_data.show_day != want.show_day)
          report_mismatch("show_day", out_data.show_day, want.show_day);
        if (out_data.show_hour != want.show_hour)
          report_mismatch("show_hour", out_data.show_hour, want.show_hour);
        if (out_data.show_minute != want.show_minute)
          report_mismatch("show_minute", out_data.show_minute, want.show_minute);
        if (out_data.show_second != want.show_second)
          report_mismatch("show_second", out_data.show_second, want.show_second);
        if (out_data.rtc_write != want.rtc_write)
          report_mismatch("rtc_write", out_data.rtc_write, want.rtc_write);
        if (want.rtc_write) writes_seen++;
        if (want.mode == MODE_CODE_ALARM) alarm_results++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      if ($urandom_range(63) == 0) out_calm <= !out_calm;
      ready_left <= gap_len(out_calm);
      if (gap_len(out_calm) != 0) out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_left <= int'($urandom_range(12));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit in_calm;
    in_item_t k;
    in_calm = 1'b0;
    pm_mode = MODE_CODE_SHOW;
    pm_field = FLD_YEAR;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      pm_time[i] = '0;
      pm_alarm[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want, 1'b0);
    end
    while (keys_sent < ITEM_TARGET) begin
      if ($urandom_range(99) == 0) in_calm = !in_calm;
      k = make_key();
      send_key(k, 1'b0, '0, in_calm);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d key events (%0d from the directed table), %0d results checked.",
             keys_sent, N_DIRECTED, results_checked);
    $display("Results in alarm mode: %0d, time writes to the clock chip: %0d, mismatches: %0d.",
             alarm_results, writes_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dtas_pkg.sv
sv/date_time_alarm_setter_core.sv
dv/date_time_alarm_setter_core_test.sv
